/* src/gbae_pkg.sv */
// ----------------------------------------------------------------------------
// Controller bind axis evaluator: shared types and constants
// Holds the bind word layout, the axis range codes and the fixed ranges
// that each bind slot maps into.
// ----------------------------------------------------------------------------
package gbae_pkg;

	localparam int NUM_SLOTS = 3;

	// Bind kind, bits 1:0 of a bind word.
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_BUTTON = 2'd1,
		KIND_HAT    = 2'd2,
		KIND_AXIS   = 2'd3
	} kind_t;

	// Axis range code, bits 3:2 of a bind word. Code 3 names no range.
	typedef enum logic [1:0] {
		RNG_FULL = 2'd0,
		RNG_POS  = 2'd1,
		RNG_NEG  = 2'd2,
		RNG_NONE = 2'd3
	} rng_t;

	// Magnitude of the rescale divisor.
	typedef enum logic [1:0] {
		DEN_65535 = 2'd0,
		DEN_32767 = 2'd1,
		DEN_32768 = 2'd2
	} den_t;

	typedef struct packed {
		logic [1:0] hat_bit;
		logic       inv;
		rng_t       src;
		kind_t      kind;
	} bind_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_SLOT0 = 2'd0;
	localparam logic [1:0] REG_SLOT1 = 2'd1;
	localparam logic [1:0] REG_SLOT2 = 2'd2;

	// Slot select codes of the digital query.
	localparam logic [1:0] SLOT_FULL = 2'd0;
	localparam logic [1:0] SLOT_POS  = 2'd1;
	localparam logic [1:0] SLOT_NEG  = 2'd2;

	localparam int AXIS_MAX = 32767;
	localparam int AXIS_MIN = -32768;

	localparam logic signed [15:0] AX_MAX16  = 16'(AXIS_MAX);
	localparam logic signed [15:0] AX_MIN16  = 16'(AXIS_MIN);
	localparam logic signed [15:0] THR_FULL  = 16'sd0;
	localparam logic signed [15:0] THR_POS   = 16'(AXIS_MAX / 2);
	localparam logic signed [15:0] THR_NEG   = 16'(AXIS_MIN / 2);

	localparam logic signed [17:0] MN_MAX18  = 18'(AXIS_MAX);
	localparam logic signed [17:0] MN_MIN18  = 18'(AXIS_MIN);
	localparam logic signed [17:0] SPAN_FULL = 18'(AXIS_MAX - AXIS_MIN);
	localparam logic signed [17:0] SPAN_HALF = 18'(AXIS_MAX);
	localparam logic signed [17:0] SPAN_NEG  = 18'(-AXIS_MIN);

	// Target range of each slot: slot 0 full, slot 1 positive, slot 2 negative.
	function automatic logic signed [15:0] tgt_min(input logic [1:0] slot);
		logic signed [15:0] v;
		case (slot)
			SLOT_FULL: v = AX_MIN16;
			default:   v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] tgt_max(input logic [1:0] slot);
		logic signed [15:0] v;
		case (slot)
			SLOT_FULL: v = AX_MAX16;
			SLOT_POS:  v = AX_MAX16;
			SLOT_NEG:  v = AX_MIN16;
			default:   v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] den_mag(input den_t d);
		logic [16:0] v;
		case (d)
			DEN_65535: v = 17'd65535;
			DEN_32767: v = 17'd32767;
			default:   v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

/* src/gamepad_bind_axis_evaluator_unit.sv */
// ----------------------------------------------------------------------------
// Controller bind axis evaluator
// Evaluates three binds per beat: a digital query of one slot or the
// wrapped sum of all three slots remapped into their target ranges.
// ----------------------------------------------------------------------------
// A beat is taken at every clock edge with start high; busy never rises, so
// one beat per cycle is sustained. Each beat produces exactly one result,
// shown with done for one cycle. The datapath has six register stages: input
// capture, bind decode, numerator build, quotient estimate, remainder, and
// correction, followed by the output register that also forms the slot sum.
// Results leave in the order the beats came in and cannot be held off by the
// receiver.
// Bind registers are written through cfg_we/cfg_idx/cfg_wdata and must only
// change while no beat is in flight; an index of three is ignored.
module gamepad_bind_axis_evaluator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [1:0]         slot_select,
	input  logic signed [15:0] raw_slot0,
	input  logic signed [15:0] raw_slot1,
	input  logic signed [15:0] raw_slot2,
	output logic               done,
	output logic               pressed,
	output logic signed [15:0] axis_value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [6:0]         cfg_wdata
);

	localparam int NS = gbae_pkg::NUM_SLOTS;

	// Bind registers.
	gbae_pkg::bind_t bind_q [NS];

	// Stage 1: captured beat.
	logic               valid_s1;
	logic               func_s1;
	logic [1:0]         sel_s1;
	logic signed [15:0] raw_s1 [NS];

	// Stage 2: decoded binds.
	logic               valid_s2, func_s2, pressed_s2;
	logic               div_s2 [NS];
	logic signed [15:0] val_s2 [NS];
	logic signed [17:0] diff_s2 [NS];
	logic signed [17:0] den_s2 [NS];
	gbae_pkg::den_t     dcode_s2 [NS];

	// Stage 3: signed numerator.
	logic               valid_s3, func_s3, pressed_s3;
	logic               div_s3 [NS];
	logic signed [15:0] val_s3 [NS];
	logic signed [35:0] num_s3 [NS];
	logic               den_neg_s3 [NS];
	gbae_pkg::den_t     dcode_s3 [NS];

	// Stage 4: magnitude and quotient estimate.
	logic               valid_s4, func_s4, pressed_s4;
	logic               div_s4 [NS];
	logic signed [15:0] val_s4 [NS];
	logic [34:0]        mag_s4 [NS];
	logic [19:0]        q0_s4 [NS];
	logic               neg_s4 [NS];
	gbae_pkg::den_t     dcode_s4 [NS];

	// Stage 5: remainder of the estimate.
	logic               valid_s5, func_s5, pressed_s5;
	logic               div_s5 [NS];
	logic signed [15:0] val_s5 [NS];
	logic [18:0]        r_s5 [NS];
	logic [19:0]        q0_s5 [NS];
	logic               neg_s5 [NS];
	gbae_pkg::den_t     dcode_s5 [NS];

	// Stage 6: final slot values.
	logic               valid_s6, func_s6, pressed_s6;
	logic signed [15:0] val_s6 [NS];

	// Output register.
	logic               done_q, pressed_q;
	logic signed [15:0] axis_q;

	// Combinational results of each stage.
	logic               dig_c [NS];
	logic               div_c [NS];
	logic signed [15:0] val_c [NS];
	logic signed [17:0] diff_c [NS];
	logic signed [17:0] den_c [NS];
	gbae_pkg::den_t     dcode_c [NS];
	logic               pressed_c;
	logic signed [35:0] num_c [NS];
	logic [34:0]        mag_c [NS];
	logic [19:0]        q0_c [NS];
	logic [18:0]        r_c [NS];
	logic signed [15:0] fin_c [NS];
	logic signed [15:0] sum_c;

	// The pipeline never stalls, so a new beat is always welcome.
	assign busy       = 1'b0;
	assign done       = done_q;
	assign pressed    = pressed_q;
	assign axis_value = axis_q;

	// ------------------------------------------------------------------------
	// Configuration writes.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				bind_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				gbae_pkg::REG_SLOT0: bind_q[0] <= gbae_pkg::bind_t'(cfg_wdata);
				gbae_pkg::REG_SLOT1: bind_q[1] <= gbae_pkg::bind_t'(cfg_wdata);
				gbae_pkg::REG_SLOT2: bind_q[2] <= gbae_pkg::bind_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Stage 2 logic: digital state of every slot, and for axis binds the
	// offset from the source minimum and the signed divisor of the rescale.
	// Binds that need no division produce their final value right here.
	// ------------------------------------------------------------------------
	always_comb begin
		gbae_pkg::bind_t    b;
		logic signed [15:0] r;
		logic signed [15:0] thr;
		logic               desc;
		logic               inr;
		for (int i = 0; i < NS; i++) begin
			b          = bind_q[i];
			r          = raw_s1[i];
			thr        = gbae_pkg::THR_FULL;
			desc       = 1'b0;
			inr        = 1'b0;
			dig_c[i]   = 1'b0;
			div_c[i]   = 1'b0;
			val_c[i]   = 16'sd0;
			diff_c[i]  = 18'sd0;
			den_c[i]   = 18'sd0;
			dcode_c[i] = gbae_pkg::DEN_32768;

			// The negative range runs downward, so its natural test is <=.
			desc = (b.src == gbae_pkg::RNG_NEG) ^ b.inv;
			case (b.src)
				gbae_pkg::RNG_POS: thr = gbae_pkg::THR_POS;
				gbae_pkg::RNG_NEG: thr = gbae_pkg::THR_NEG;
				default:           thr = gbae_pkg::THR_FULL;
			endcase

			unique case (b.kind)
				gbae_pkg::KIND_NONE: ;
				gbae_pkg::KIND_BUTTON: begin
					dig_c[i] = (r != 16'sd0);
					val_c[i] = dig_c[i] ? gbae_pkg::tgt_max(2'(i)) : gbae_pkg::tgt_min(2'(i));
				end
				gbae_pkg::KIND_HAT: begin
					dig_c[i] = r[{2'b00, b.hat_bit}];
					val_c[i] = dig_c[i] ? gbae_pkg::tgt_max(2'(i)) : gbae_pkg::tgt_min(2'(i));
				end
				gbae_pkg::KIND_AXIS: begin
					dig_c[i] = (b.src != gbae_pkg::RNG_NONE) &&
					           (desc ? (r <= thr) : (r >= thr));
					case (b.src)
						gbae_pkg::RNG_FULL: begin
							inr        = 1'b1;
							diff_c[i]  = 18'(r) - (b.inv ? gbae_pkg::MN_MAX18 : gbae_pkg::MN_MIN18);
							den_c[i]   = b.inv ? -gbae_pkg::SPAN_FULL : gbae_pkg::SPAN_FULL;
							dcode_c[i] = gbae_pkg::DEN_65535;
						end
						gbae_pkg::RNG_POS: begin
							inr        = !r[15];
							diff_c[i]  = 18'(r) - (b.inv ? gbae_pkg::MN_MAX18 : 18'sd0);
							den_c[i]   = b.inv ? -gbae_pkg::SPAN_HALF : gbae_pkg::SPAN_HALF;
							dcode_c[i] = gbae_pkg::DEN_32767;
						end
						gbae_pkg::RNG_NEG: begin
							inr        = r[15] || (r == 16'sd0);
							diff_c[i]  = 18'(r) - (b.inv ? gbae_pkg::MN_MIN18 : 18'sd0);
							den_c[i]   = b.inv ? gbae_pkg::SPAN_NEG : -gbae_pkg::SPAN_NEG;
							dcode_c[i] = gbae_pkg::DEN_32768;
						end
						default: inr = 1'b0;
					endcase
					// A source range equal to the target range passes through.
					if (inr) begin
						if ((b.src == 2'(i)) && !b.inv) begin
							val_c[i] = r;
						end else begin
							div_c[i] = 1'b1;
						end
					end
				end
			endcase
		end

		case (sel_s1)
			gbae_pkg::SLOT_FULL: pressed_c = dig_c[0];
			gbae_pkg::SLOT_POS:  pressed_c = dig_c[1];
			gbae_pkg::SLOT_NEG:  pressed_c = dig_c[2];
			default:             pressed_c = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Stage 3 logic: numerator diff * target span + target min * divisor.
	// The spans are constants, so each product is built from shifts and subtracts.
	// ------------------------------------------------------------------------
	always_comb begin
		logic signed [35:0] dx;
		logic signed [35:0] bias;
		for (int i = 0; i < NS; i++) begin
			dx   = 36'(diff_s2[i]);
			bias = 36'sd0;
			if (i == 0) begin
				// Only the full range has a nonzero target minimum.
				bias     = -(36'(den_s2[i]) <<< 15);
				num_c[i] = (dx <<< 16) - dx + bias;
			end else if (i == 1) begin
				num_c[i] = (dx <<< 15) - dx;
			end else begin
				num_c[i] = -(dx <<< 15);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stage 4 logic: magnitude of the numerator and a quotient estimate that
	// never exceeds the true quotient. Division by 2^k-1 is a sum of shifts.
	// ------------------------------------------------------------------------
	always_comb begin
		logic [35:0] a;
		for (int i = 0; i < NS; i++) begin
			a        = num_s3[i][35] ? 36'(-num_s3[i]) : 36'(num_s3[i]);
			mag_c[i] = a[34:0];
			case (dcode_s3[i])
				gbae_pkg::DEN_65535: q0_c[i] = 20'(mag_c[i] >> 16) + 20'(mag_c[i] >> 32);
				gbae_pkg::DEN_32767: q0_c[i] = 20'(mag_c[i] >> 15) + 20'(mag_c[i] >> 30);
				default:             q0_c[i] = 20'(mag_c[i] >> 15);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Stage 5 logic: remainder left by the estimate, below four divisors.
	// ------------------------------------------------------------------------
	always_comb begin
		logic [35:0] qd;
		for (int i = 0; i < NS; i++) begin
			case (dcode_s4[i])
				gbae_pkg::DEN_65535: qd = (36'(q0_s4[i]) << 16) - 36'(q0_s4[i]);
				gbae_pkg::DEN_32767: qd = (36'(q0_s4[i]) << 15) - 36'(q0_s4[i]);
				default:             qd = 36'(q0_s4[i]) << 15;
			endcase
			r_c[i] = 19'(36'(mag_s4[i]) - qd);
		end
	end

	function automatic logic r_c_ge(input logic [18:0] a, input logic [18:0] b);
		return a >= b;
	endfunction

	// ------------------------------------------------------------------------
	// Stage 6 logic: up to three corrections, then the sign. The quotient is
	// truncated toward zero, so the sign applies to the floored magnitude.
	// ------------------------------------------------------------------------
	always_comb begin
		logic [18:0] d;
		logic [1:0]  cnt;
		logic [19:0] qm;
		logic [19:0] qs;
		for (int i = 0; i < NS; i++) begin
			d   = 19'(gbae_pkg::den_mag(dcode_s5[i]));
			cnt = 2'(r_c_ge(r_s5[i], d)) + 2'(r_c_ge(r_s5[i], d << 1))
			    + 2'(r_c_ge(r_s5[i], (d << 1) + d));
			qm  = q0_s5[i] + 20'(cnt);
			qs  = neg_s5[i] ? -qm : qm;
			fin_c[i] = div_s5[i] ? 16'(qs) : val_s5[i];
		end
	end

	assign sum_c = val_s6[0] + val_s6[1] + val_s6[2];

	// ------------------------------------------------------------------------
	// Valid bits.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	// ------------------------------------------------------------------------
	// Datapath registers.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		func_s1   <= func;
		sel_s1    <= slot_select;
		raw_s1[0] <= raw_slot0;
		raw_s1[1] <= raw_slot1;
		raw_s1[2] <= raw_slot2;

		func_s2    <= func_s1;
		pressed_s2 <= pressed_c;
		func_s3    <= func_s2;
		pressed_s3 <= pressed_s2;
		func_s4    <= func_s3;
		pressed_s4 <= pressed_s3;
		func_s5    <= func_s4;
		pressed_s5 <= pressed_s4;
		func_s6    <= func_s5;
		pressed_s6 <= pressed_s5;

		for (int i = 0; i < NS; i++) begin
			div_s2[i]   <= div_c[i];
			val_s2[i]   <= val_c[i];
			diff_s2[i]  <= diff_c[i];
			den_s2[i]   <= den_c[i];
			dcode_s2[i] <= dcode_c[i];

			div_s3[i]     <= div_s2[i];
			val_s3[i]     <= val_s2[i];
			num_s3[i]     <= num_c[i];
			den_neg_s3[i] <= den_s2[i][17];
			dcode_s3[i]   <= dcode_s2[i];

			div_s4[i]   <= div_s3[i];
			val_s4[i]   <= val_s3[i];
			mag_s4[i]   <= mag_c[i];
			q0_s4[i]    <= q0_c[i];
			neg_s4[i]   <= num_s3[i][35] ^ den_neg_s3[i];
			dcode_s4[i] <= dcode_s3[i];

			div_s5[i]   <= div_s4[i];
			val_s5[i]   <= val_s4[i];
			r_s5[i]     <= r_c[i];
			q0_s5[i]    <= q0_s4[i];
			neg_s5[i]   <= neg_s4[i];
			dcode_s5[i] <= dcode_s4[i];

			val_s6[i] <= fin_c[i];
		end

		pressed_q <= func_s6 ? 1'b0 : pressed_s6;
		axis_q    <= func_s6 ? sum_c : 16'sd0;
	end

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("beat taken without a matching result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result strobe without a matching beat");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!pressed || (axis_value == 16'sd0)))
		else $error("digital and analog result both nonzero");

	for (genvar g = 0; g < NS; g++) begin : g_rem_chk
		a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
			(valid_s5 && div_s5[g]) |->
			(r_s5[g] < (19'(gbae_pkg::den_mag(dcode_s5[g])) << 2)))
			else $error("quotient estimate off by more than three");
	end

endmodule

/* dv/gamepad_bind_axis_evaluator_unit_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result checker for the controller bind axis evaluator
// Follows the bind writes, predicts the result of every accepted beat from
// its own copy of the bind words and compares the results in order.
// ----------------------------------------------------------------------------
module gamepad_bind_axis_evaluator_unit_chk (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic [1:0]         slot_select,
	input  logic signed [15:0] raw_slot0,
	input  logic signed [15:0] raw_slot1,
	input  logic signed [15:0] raw_slot2,
	input  logic               done,
	input  logic               pressed,
	input  logic signed [15:0] axis_value,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [6:0]         cfg_wdata,
	output int                 err_count,
	output int                 outstanding
);

	typedef struct packed {
		logic               pressed;
		logic signed [15:0] axis_value;
	} eval_t;

	gbae_pkg::bind_t bind_word [gbae_pkg::NUM_SLOTS];
	eval_t           awaited_evals [$];
	int              mismatches = 0;
	int              awaited_n = 0;

	assign err_count   = mismatches;
	assign outstanding = awaited_n;

	// First and last value of each axis range, and its press threshold.
	function automatic int range_first(gbae_pkg::rng_t r);
		case (r)
			gbae_pkg::RNG_FULL: return gbae_pkg::AXIS_MIN;
			default:            return 0;
		endcase
	endfunction

	function automatic int range_last(gbae_pkg::rng_t r);
		case (r)
			gbae_pkg::RNG_FULL: return gbae_pkg::AXIS_MAX;
			gbae_pkg::RNG_POS:  return gbae_pkg::AXIS_MAX;
			gbae_pkg::RNG_NEG:  return gbae_pkg::AXIS_MIN;
			default:            return 0;
		endcase
	endfunction

	function automatic int range_thr(gbae_pkg::rng_t r);
		case (r)
			gbae_pkg::RNG_POS: return gbae_pkg::AXIS_MAX / 2;
			gbae_pkg::RNG_NEG: return gbae_pkg::AXIS_MIN / 2;
			default:           return 0;
		endcase
	endfunction

	function automatic logic digital_state(gbae_pkg::bind_t b, logic signed [15:0] raw);
		int   r;
		logic desc;
		r = raw;
		case (b.kind)
			gbae_pkg::KIND_BUTTON: return r != 0;
			gbae_pkg::KIND_HAT:    return raw[b.hat_bit];
			gbae_pkg::KIND_AXIS: begin
				if (b.src == gbae_pkg::RNG_NONE)
					return 1'b0;
				desc = (range_first(b.src) > range_last(b.src)) ^ b.inv;
				if (desc)
					return r <= range_thr(b.src);
				return r >= range_thr(b.src);
			end
			default: return 1'b0;
		endcase
	endfunction

	// Value of one slot after mapping into the target range of that slot.
	function automatic int slot_remap(gbae_pkg::bind_t b, logic signed [15:0] raw,
			gbae_pkg::rng_t tgt);
		int     r, mn, mx, t, tmin, tmax;
		longint num, den;
		r    = raw;
		tmin = range_first(tgt);
		tmax = range_last(tgt);
		if (b.kind == gbae_pkg::KIND_BUTTON || b.kind == gbae_pkg::KIND_HAT)
			return digital_state(b, raw) ? tmax : tmin;
		if (b.kind != gbae_pkg::KIND_AXIS || b.src == gbae_pkg::RNG_NONE)
			return 0;
		mn = range_first(b.src);
		mx = range_last(b.src);
		if (b.inv) begin
			t  = mn;
			mn = mx;
			mx = t;
		end
		if (r < ((mn < mx) ? mn : mx) || r > ((mn < mx) ? mx : mn))
			return 0;
		if (mn == tmin && mx == tmax)
			return r;
		den = longint'(mx) - longint'(mn);
		num = (longint'(r) - longint'(mn)) * (longint'(tmax) - longint'(tmin))
			+ longint'(tmin) * den;
		return int'(num / den);
	endfunction

	function automatic eval_t predict_eval(logic f, logic [1:0] sel,
			logic signed [15:0] r0, logic signed [15:0] r1, logic signed [15:0] r2);
		eval_t              e;
		logic signed [15:0] raw [gbae_pkg::NUM_SLOTS];
		logic [15:0]        sum;
		int                 i;
		raw[0] = r0;
		raw[1] = r1;
		raw[2] = r2;
		e      = '0;
		sum    = '0;
		if (!f) begin
			if (sel == gbae_pkg::SLOT_FULL || sel == gbae_pkg::SLOT_POS
					|| sel == gbae_pkg::SLOT_NEG)
				e.pressed = digital_state(bind_word[sel], raw[sel]);
		end else begin
			for (i = 0; i < gbae_pkg::NUM_SLOTS; i++)
				sum = sum + 16'(slot_remap(bind_word[i], raw[i], gbae_pkg::rng_t'(i)));
			e.axis_value = sum;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		eval_t want;
		int    i;
		if (!arst_n) begin
			for (i = 0; i < gbae_pkg::NUM_SLOTS; i++)
				bind_word[i] = '0;
			awaited_evals.delete();
			awaited_n <= 0;
		end else begin
			// A result leaving and a beat entering at one edge: retire first.
			if (done) begin
				if (awaited_evals.size() == 0) begin
					$display("%0t: result with nothing awaited: pressed %0b axis_value %0d",
						$time, pressed, axis_value);
					mismatches++;
				end else begin
					want = awaited_evals.pop_front();
					if (pressed !== want.pressed) begin
						$display("%0t: pressed expected %0b actual %0b",
							$time, want.pressed, pressed);
						mismatches++;
					end
					if (axis_value !== want.axis_value) begin
						$display("%0t: axis_value expected %0d actual %0d",
							$time, want.axis_value, axis_value);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				awaited_evals.push_back(predict_eval(func, slot_select,
					raw_slot0, raw_slot1, raw_slot2));
			if (cfg_we && (cfg_idx == gbae_pkg::REG_SLOT0 || cfg_idx == gbae_pkg::REG_SLOT1
					|| cfg_idx == gbae_pkg::REG_SLOT2))
				bind_word[cfg_idx] = gbae_pkg::bind_t'(cfg_wdata);
			awaited_n <= awaited_evals.size();
		end
	end

endmodule

/* dv/gamepad_bind_axis_evaluator_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the controller bind axis evaluator
// Loads bind words, sends directed corner beats and then random beats under
// several bind settings and sender idle rates; a checker beside the block
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module gamepad_bind_axis_evaluator_unit_tb;

	// Number of random beats, and how many go by before the binds change.
	localparam int BEATS_RANDOM = 1950;
	localparam int BEATS_PER_SETTING = 30;
	// Extra cycles waited once every result is back, as slack.
	localparam int SETTLE_CYCLES = 10;
	localparam int END_WAIT_LIMIT = 200;
	// The block has no register at this index; writes to it must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               func = 1'b0;
	logic [1:0]         slot_select = '0;
	logic signed [15:0] raw_slot0 = '0;
	logic signed [15:0] raw_slot1 = '0;
	logic signed [15:0] raw_slot2 = '0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_idx = '0;
	logic [6:0]         cfg_wdata = '0;
	logic               busy;
	logic               done;
	logic               pressed;
	logic signed [15:0] axis_value;
	int                 err_count;
	int                 outstanding;

	// Chance in percent that the sender idles before a beat, drawn again after each idle.
	int idle_pct = 29;

	always #2 clk = ~clk;

	gamepad_bind_axis_evaluator_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.slot_select(slot_select),
		.raw_slot0  (raw_slot0),
		.raw_slot1  (raw_slot1),
		.raw_slot2  (raw_slot2),
		.done       (done),
		.pressed    (pressed),
		.axis_value (axis_value),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	gamepad_bind_axis_evaluator_unit_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.slot_select(slot_select),
		.raw_slot0  (raw_slot0),
		.raw_slot1  (raw_slot1),
		.raw_slot2  (raw_slot2),
		.done       (done),
		.pressed    (pressed),
		.axis_value (axis_value),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.err_count  (err_count),
		.outstanding(outstanding)
	);

	function automatic logic [6:0] mk_bind(gbae_pkg::kind_t k, gbae_pkg::rng_t s,
			logic inv, logic [1:0] hb);
		return {hb, inv, s, k};
	endfunction

	// Random bind word. Half of them are forced to be an axis with a real
	// source range, since that is where the rescale arithmetic lives; the
	// rest cover buttons, hats, empty binds and the missing range code.
	function automatic logic [6:0] pick_bind();
		logic [6:0] w;
		w = 7'($urandom_range(127));
		if ($urandom_range(1)) begin
			w[1:0] = gbae_pkg::KIND_AXIS;
			if (w[3:2] == gbae_pkg::RNG_NONE)
				w[3:2] = 2'($urandom_range(2));
		end
		return w;
	endfunction

	// Random sample, weighted toward the range ends, the press thresholds,
	// zero and small hat masks; the rest is spread over the whole word.
	function automatic logic [15:0] pick_raw();
		case ($urandom_range(7))
			0:       return 16'(gbae_pkg::AXIS_MIN + int'($urandom_range(2)));
			1:       return 16'(gbae_pkg::AXIS_MAX - int'($urandom_range(2)));
			2:       return 16'(gbae_pkg::AXIS_MAX / 2 + int'($urandom_range(2)) - 1);
			3:       return 16'(gbae_pkg::AXIS_MIN / 2 + int'($urandom_range(2)) - 1);
			4:       return 16'(int'($urandom_range(4)) - 2);
			5:       return 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	// Corner samples for the directed beats: both range ends, each press threshold
	// and the next value farther from zero, and zero and minus one.
	function automatic logic [15:0] corner_raw(int k);
		case (k)
			0:       return 16'(gbae_pkg::AXIS_MIN);
			1:       return 16'(gbae_pkg::AXIS_MIN / 2 - 1);
			2:       return 16'(gbae_pkg::AXIS_MIN / 2);
			3:       return 16'hffff;
			4:       return 16'h0000;
			5:       return 16'(gbae_pkg::AXIS_MAX / 2);
			6:       return 16'(gbae_pkg::AXIS_MAX / 2 + 1);
			default: return 16'(gbae_pkg::AXIS_MAX);
		endcase
	endfunction

	// Holds start low until every result is back, then lets the pipeline
	// run empty through a settling wait before anything touches the binds.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three bind words on back-to-back cycles, sometimes followed
	// by a write to the unused index, and only then drops the write enable.
	task automatic load_binds(logic [6:0] b0, logic [6:0] b1, logic [6:0] b2);
		cfg_we    <= 1'b1;
		cfg_idx   <= gbae_pkg::REG_SLOT0;
		cfg_wdata <= b0;
		@(posedge clk);
		cfg_idx   <= gbae_pkg::REG_SLOT1;
		cfg_wdata <= b1;
		@(posedge clk);
		cfg_idx   <= gbae_pkg::REG_SLOT2;
		cfg_wdata <= b2;
		@(posedge clk);
		if ($urandom_range(3) == 0) begin
			cfg_idx   <= REG_UNUSED;
			cfg_wdata <= 7'($urandom_range(127));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one beat. The sender may first sit out some cycles with start
	// low; then start is raised with the fields and held until busy is low
	// at an edge. Start is left high so that the next beat can follow on the
	// very next cycle without a bubble.
	task automatic send_beat(logic f, logic [1:0] sel,
			logic [15:0] r0, logic [15:0] r1, logic [15:0] r2);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		func        <= f;
		slot_select <= sel;
		raw_slot0   <= r0;
		raw_slot1   <= r1;
		raw_slot2   <= r2;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Eight corner beats under one bind setting: func alternates, the slot
	// select walks through all four codes, including the one with no slot,
	// and each slot sees the corner samples in a different order.
	task automatic corner_pass(logic [6:0] b0, logic [6:0] b1, logic [6:0] b2);
		int k;
		load_binds(b0, b1, b2);
		for (k = 0; k < 8; k++)
			send_beat(k[0], 2'(k / 2), corner_raw(k), corner_raw(7 - k),
				corner_raw((k + 3) % 8));
		wait_idle();
	endtask

	initial begin
		int n;
		int w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain axes: every source range mapped into its own target, so
		// values in range pass straight through.
		corner_pass(mk_bind(gbae_pkg::KIND_AXIS, gbae_pkg::RNG_FULL, 1'b0, 2'd0),
			mk_bind(gbae_pkg::KIND_AXIS, gbae_pkg::RNG_POS, 1'b0, 2'd0),
			mk_bind(gbae_pkg::KIND_AXIS, gbae_pkg::RNG_NEG, 1'b0, 2'd0));
		// All-ones bind word (an axis without a source range), and inverted
		// axes whose source differs from the target, so the rescale runs.
		corner_pass(7'h7f,
			mk_bind(gbae_pkg::KIND_AXIS, gbae_pkg::RNG_NEG, 1'b1, 2'd3),
			mk_bind(gbae_pkg::KIND_AXIS, gbae_pkg::RNG_FULL, 1'b1, 2'd0));
		// A button, a hat on its third bit, and an empty all-zero bind.
		corner_pass(mk_bind(gbae_pkg::KIND_BUTTON, gbae_pkg::RNG_FULL, 1'b0, 2'd0),
			mk_bind(gbae_pkg::KIND_HAT, gbae_pkg::RNG_NONE, 1'b0, 2'd2),
			7'h00);

		// Random beats. The bind setting changes every few dozen beats; the
		// sender idles often in the first third, more often in the second,
		// and never in the last.
		for (n = 0; n < BEATS_RANDOM; n++) begin
			if (n % BEATS_PER_SETTING == 0) begin
				wait_idle();
				if (n < BEATS_RANDOM / 3)
					idle_pct = 29;
				else if (n < 2 * BEATS_RANDOM / 3)
					idle_pct = 54;
				else
					idle_pct = 0;
				load_binds(pick_bind(), pick_bind(), pick_bind());
			end
			send_beat(1'($urandom_range(1)), 2'($urandom_range(SLOT_NONE)),
				pick_raw(), pick_raw(), pick_raw());
		end

		// Drain: wait for the last results, then keep watching through a settling
		// wait so that a stray strobe would still be caught.
		start <= 1'b0;
		@(posedge clk);
		for (w = 0; w < END_WAIT_LIMIT && outstanding != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && outstanding == 0)
			$display("gamepad_bind_axis_evaluator_unit_tb: clean");
		else
			$display("gamepad_bind_axis_evaluator_unit_tb: errors");
		$finish;
	end

	// Watchdog. A run that has not finished in time is reported as errors.
	initial begin
		#2000000;
		$display("gamepad_bind_axis_evaluator_unit_tb: errors");
		$finish;
	end

endmodule

/* sim.f */
src/gbae_pkg.sv
src/gamepad_bind_axis_evaluator_unit.sv
dv/gamepad_bind_axis_evaluator_unit_chk.sv
dv/gamepad_bind_axis_evaluator_unit_tb.sv
